>>> sv/ospf_packet_validator_defines.svh
// Assertion macros shared by the validator modules.
`ifndef OSPF_PACKET_VALIDATOR_DEFINES_SVH
`define OSPF_PACKET_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OPV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("validator assertion failed");

// Next-cycle implication, disabled during reset.
`define OPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("validator assertion failed");

`endif

>>> sv/opv_pkg.sv
// Shared types and constants of the OSPF packet validator.
`timescale 1ns / 1ps
`default_nettype none
package opv_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  VERSION_RESET = 8'd2;
  localparam logic [7:0]  TYPE_HELLO    = 8'd1;
  localparam logic [7:0]  TYPE_LSU      = 8'd4;
  localparam logic [31:0] HELLO_DST     = 32'hE000_0005;
  localparam logic [16:0] BASE_LEN      = 17'd24;
  localparam logic [16:0] HELLO_LEN     = 17'd32;
  localparam logic [35:0] LSU_BASE_LEN  = 36'd32;

  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_SHORT     = 4'd1;
  localparam logic [3:0] ERR_LEN       = 4'd2;
  localparam logic [3:0] ERR_VERSION   = 4'd3;
  localparam logic [3:0] ERR_AUTH      = 4'd4;
  localparam logic [3:0] ERR_TYPE      = 4'd5;
  localparam logic [3:0] ERR_CKSUM     = 4'd6;
  localparam logic [3:0] ERR_HELLO_LEN = 4'd7;
  localparam logic [3:0] ERR_PADDING   = 4'd8;
  localparam logic [3:0] ERR_DST       = 4'd9;
  localparam logic [3:0] ERR_LSU_LEN   = 4'd10;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_HELLO = 2'd1;
  localparam logic [1:0] KIND_LSU   = 2'd2;

  // Everything the verdict needs, captured at the end of one packet.
  typedef struct packed {
    logic [16:0] byte_count;
    logic [15:0] length_seen;
    logic [7:0]  version_seen;
    logic [7:0]  type_seen;
    logic [15:0] sum;
    logic [15:0] stored_checksum;
    logic        auth_nonzero;
    logic        padding_nonzero;
    logic [31:0] advert_count;
    logic [31:0] ip_dst;
    logic        ip_header_present;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

>>> sv/ospf_packet_validator.sv
// Top level of the streaming OSPF packet header validator.
// Takes one packet byte per clock while in_stall is low and gives one verdict
// per packet, on the item carrying last_byte. The byte front end does a single 16-bit
// ones-complement add and field capture per byte; at the last byte it hands a job to a
// queue of QueueDepth entries, and the back end runs the checks and registers the result.
// The job waits in a queue entry until the back end pops it and registers the verdict;
// out_stall can hold it there. in_stall rises only when the queue is full, i.e. when results
// are held back by out_stall; packets of a single byte each can still be taken one per
// cycle while the output flows.
`timescale 1ns / 1ps
`default_nettype none
module ospf_packet_validator #(
  parameter int QueueDepth = opv_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [7:0]  cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] ip_dst,
  input  wire logic        ip_header_present,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             packet_ok,
  output logic [3:0]       error_code,
  output logic [1:0]       packet_kind
);

  logic [7:0]          expected_version_reg;
  logic                accept;
  logic                push;
  logic                pop;
  opv_pkg::job_t       push_job;
  opv_pkg::job_t       head_job;
  opv_pkg::q_status_t  status;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version_reg <= opv_pkg::VERSION_RESET;
    end else if (cfg_write_en) begin
      expected_version_reg <= cfg_write_data;
    end
  end

  assign in_stall = status.full;
  assign accept   = in_valid & ~in_stall;

  opv_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .ip_dst            (ip_dst),
    .ip_header_present (ip_header_present),
    .push              (push),
    .push_job          (push_job)
  );

  opv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (status)
  );

  opv_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_job         (head_job),
    .status           (status),
    .expected_version (expected_version_reg),
    .out_stall        (out_stall),
    .pop              (pop),
    .out_valid        (out_valid),
    .packet_ok        (packet_ok),
    .error_code       (error_code),
    .packet_kind      (packet_kind)
  );

endmodule
`default_nettype wire

>>> sv/opv_front.sv
// Byte front end: counts, captures header fields and sums, emits one job per packet.
`timescale 1ns / 1ps
`default_nettype none
`include "ospf_packet_validator_defines.svh"
module opv_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire logic [31:0]   ip_dst,
  input  wire logic          ip_header_present,
  output logic               push,
  output opv_pkg::job_t      push_job
);

  logic [16:0] byte_count;
  logic [15:0] sum;
  logic [7:0]  high_byte_hold;
  logic [7:0]  version_seen;
  logic [7:0]  type_seen;
  logic [15:0] length_seen;
  logic [15:0] stored_checksum;
  logic        auth_nonzero;
  logic        padding_nonzero;
  logic [31:0] advert_count;

  logic [16:0] byte_count_upd;
  logic [15:0] sum_upd;
  logic [7:0]  high_byte_hold_upd;
  logic [7:0]  version_upd;
  logic [7:0]  type_upd;
  logic [15:0] length_upd;
  logic [15:0] checksum_upd;
  logic        auth_upd;
  logic        padding_upd;
  logic [31:0] advert_upd;

  logic        live;
  logic        even;
  logic [7:0]  v;
  logic [15:0] add_word;
  logic [16:0] raw_sum;
  logic [15:0] folded;

  assign live = ~byte_count[16];
  assign even = ~byte_count[0];
  // checksum field itself counts as zero in the sum
  assign v = (byte_count == 17'd12 || byte_count == 17'd13) ? 8'h00 : data_byte;
  // an even byte on its own (odd-length tail) is padded low
  assign add_word = even ? {v, 8'h00} : {high_byte_hold, v};
  assign raw_sum = {1'b0, sum} + {1'b0, add_word};
  assign folded = raw_sum[16] ? (raw_sum[15:0] + 16'd1) : raw_sum[15:0];

  always_comb begin
    byte_count_upd     = byte_count;
    sum_upd            = sum;
    high_byte_hold_upd = high_byte_hold;
    version_upd        = version_seen;
    type_upd           = type_seen;
    length_upd         = length_seen;
    checksum_upd       = stored_checksum;
    auth_upd           = auth_nonzero;
    padding_upd        = padding_nonzero;
    advert_upd         = advert_count;
    if (live) begin
      case (byte_count)
        17'd0:   version_upd  = data_byte;
        17'd1:   type_upd     = data_byte;
        17'd2:   length_upd   = {data_byte, 8'h00};
        17'd3:   length_upd   = {length_seen[15:8], data_byte};
        17'd12:  checksum_upd = {data_byte, 8'h00};
        17'd13:  checksum_upd = {stored_checksum[15:8], data_byte};
        default: ;
      endcase
      if (byte_count >= 17'd14 && byte_count <= 17'd23 && data_byte != 8'h00) begin
        auth_upd = 1'b1;
      end
      if (byte_count >= 17'd28 && byte_count <= 17'd31) begin
        advert_upd = {advert_count[23:0], data_byte};
      end
      if ((byte_count == 17'd30 || byte_count == 17'd31) && data_byte != 8'h00) begin
        padding_upd = 1'b1;
      end
      if (even) begin
        high_byte_hold_upd = v;
      end
      if (!even || last_byte) begin
        sum_upd = folded;
      end
      byte_count_upd = byte_count + 17'd1;
    end
  end

  assign push = accept & last_byte;

  always_comb begin
    push_job.byte_count        = byte_count_upd;
    push_job.length_seen       = length_upd;
    push_job.version_seen      = version_upd;
    push_job.type_seen         = type_upd;
    push_job.sum               = sum_upd;
    push_job.stored_checksum   = checksum_upd;
    push_job.auth_nonzero      = auth_upd;
    push_job.padding_nonzero   = padding_upd;
    push_job.advert_count      = advert_upd;
    push_job.ip_dst            = ip_dst;
    push_job.ip_header_present = ip_header_present;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count      <= '0;
      sum             <= '0;
      high_byte_hold  <= '0;
      version_seen    <= '0;
      type_seen       <= '0;
      length_seen     <= '0;
      stored_checksum <= '0;
      auth_nonzero    <= 1'b0;
      padding_nonzero <= 1'b0;
      advert_count    <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_upd;
      sum             <= sum_upd;
      high_byte_hold  <= high_byte_hold_upd;
      version_seen    <= version_upd;
      type_seen       <= type_upd;
      length_seen     <= length_upd;
      stored_checksum <= checksum_upd;
      auth_nonzero    <= auth_upd;
      padding_nonzero <= padding_upd;
      advert_count    <= advert_upd;
    end
  end

  `OPV_ASSERT_NEXT(a_clear_after_last, clk, rst, push, byte_count == 17'd0 && sum == 16'd0)
  `OPV_ASSERT_IMP(a_count_saturates, clk, rst, byte_count[16], byte_count[15:0] == 16'd0)

endmodule
`default_nettype wire

>>> sv/opv_queue.sv
// Short job queue between the byte front end and the verdict back end.
`timescale 1ns / 1ps
`default_nettype none
`include "ospf_packet_validator_defines.svh"
module opv_queue #(
  parameter int Depth = opv_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire opv_pkg::job_t  push_job,
  input  wire logic           pop,
  output opv_pkg::job_t       head_job,
  output opv_pkg::q_status_t  status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  opv_pkg::job_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head_job     = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CntW'(Depth));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `OPV_ASSERT_IMP(a_no_overflow, clk, rst, push, !status.full)
  `OPV_ASSERT_IMP(a_no_underflow, clk, rst, pop, !status.empty)

endmodule
`default_nettype wire

>>> sv/opv_back.sv
// Verdict back end: runs the checks in order on one job and registers the result.
`timescale 1ns / 1ps
`default_nettype none
`include "ospf_packet_validator_defines.svh"
module opv_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire opv_pkg::job_t       head_job,
  input  wire opv_pkg::q_status_t  status,
  input  wire logic [7:0]          expected_version,
  input  wire logic                out_stall,
  output logic                     pop,
  output logic                     out_valid,
  output logic                     packet_ok,
  output logic [3:0]               error_code,
  output logic [1:0]               packet_kind
);

  logic [35:0] need;
  logic [3:0]  err;
  logic [1:0]  kind;
  logic        is_hello;
  logic        is_lsu;

  assign is_hello = (head_job.type_seen == opv_pkg::TYPE_HELLO);
  assign is_lsu   = (head_job.type_seen == opv_pkg::TYPE_LSU);
  // 32 + 12 * adverts, as 8a + 4a
  assign need = opv_pkg::LSU_BASE_LEN + {1'b0, head_job.advert_count, 3'b000}
              + {2'b00, head_job.advert_count, 2'b00};

  always_comb begin
    err = opv_pkg::ERR_OK;
    if (head_job.byte_count < opv_pkg::BASE_LEN) begin
      err = opv_pkg::ERR_SHORT;
    end else if (head_job.byte_count != {1'b0, head_job.length_seen}) begin
      err = opv_pkg::ERR_LEN;
    end else if (head_job.version_seen != expected_version) begin
      err = opv_pkg::ERR_VERSION;
    end else if (head_job.auth_nonzero) begin
      err = opv_pkg::ERR_AUTH;
    end else if (!is_hello && !is_lsu) begin
      err = opv_pkg::ERR_TYPE;
    end else if (~head_job.sum != head_job.stored_checksum) begin
      err = opv_pkg::ERR_CKSUM;
    end else if (is_hello) begin
      if (head_job.byte_count < opv_pkg::HELLO_LEN) begin
        err = opv_pkg::ERR_HELLO_LEN;
      end else if (head_job.padding_nonzero) begin
        err = opv_pkg::ERR_PADDING;
      end else if (head_job.ip_header_present && head_job.ip_dst != opv_pkg::HELLO_DST) begin
        err = opv_pkg::ERR_DST;
      end
    end else if ({19'd0, head_job.byte_count} < need) begin
      err = opv_pkg::ERR_LSU_LEN;
    end
  end

  assign kind = is_hello ? opv_pkg::KIND_HELLO :
                is_lsu   ? opv_pkg::KIND_LSU : opv_pkg::KIND_OTHER;

  assign pop = !status.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      packet_ok   <= (err == opv_pkg::ERR_OK);
      error_code  <= err;
      packet_kind <= kind;
    end
  end

  `OPV_ASSERT_IMP(a_ok_matches_code, clk, rst, out_valid,
                  packet_ok == (error_code == opv_pkg::ERR_OK))
  `OPV_ASSERT_NEXT(a_pop_shows_result, clk, rst, pop, out_valid)

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the streaming OSPF packet header validator.
`timescale 1ns / 1ps
module tb;

  typedef bit [7:0] octets_t[$];

  typedef struct packed {
    logic       ok;
    logic [3:0] code;
    logic [1:0] kind;
  } verdict_t;

  localparam int unsigned SAT_COUNT = 65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [7:0]  cfg_write_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic [31:0] ip_dst = 32'h0;
  logic        ip_header_present = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        packet_ok;
  logic [3:0]  error_code;
  logic [1:0]  packet_kind;

  ospf_packet_validator dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .ip_dst(ip_dst),
    .ip_header_present(ip_header_present),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .packet_ok(packet_ok),
    .error_code(error_code),
    .packet_kind(packet_kind)
  );

  always #5 clk = ~clk;

  // Verdict tracker: mirror of the per-packet capture state
  bit [7:0]  cur_version = opv_pkg::VERSION_RESET;
  bit [16:0] cnt;
  bit [16:0] sum;
  bit [7:0]  hi_hold;
  bit [7:0]  ver;
  bit [7:0]  typ;
  bit [15:0] len;
  bit [15:0] ck;
  bit        auth;
  bit        pad;
  bit [31:0] adverts;

  verdict_t verdicts_due[$];
  int unsigned mismatches = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int unsigned hold_request = 0;

  function automatic bit [16:0] ones_acc(bit [16:0] acc, bit [15:0] w);
    bit [16:0] s;
    s = acc + w;
    if (s > 17'h0FFFF) s = {1'b0, s[15:0]} + 17'd1;
    return s;
  endfunction

  function automatic logic [3:0] verdict_code(bit [31:0] dst, bit present);
    logic [35:0] need;
    need = opv_pkg::LSU_BASE_LEN + 36'd12 * adverts;
    if (cnt < opv_pkg::BASE_LEN) return opv_pkg::ERR_SHORT;
    if (cnt != {1'b0, len}) return opv_pkg::ERR_LEN;
    if (ver != cur_version) return opv_pkg::ERR_VERSION;
    if (auth) return opv_pkg::ERR_AUTH;
    if (typ != opv_pkg::TYPE_HELLO && typ != opv_pkg::TYPE_LSU) return opv_pkg::ERR_TYPE;
    if ((16'hFFFF - sum[15:0]) != ck) return opv_pkg::ERR_CKSUM;
    if (typ == opv_pkg::TYPE_HELLO) begin
      if (cnt < opv_pkg::HELLO_LEN) return opv_pkg::ERR_HELLO_LEN;
      if (pad) return opv_pkg::ERR_PADDING;
      if (present && dst != opv_pkg::HELLO_DST) return opv_pkg::ERR_DST;
    end else if ({19'd0, cnt} < need) begin
      return opv_pkg::ERR_LSU_LEN;
    end
    return opv_pkg::ERR_OK;
  endfunction

  function automatic void absorb_byte(bit [7:0] b, bit fin, bit [31:0] dst, bit present);
    bit [16:0] idx;
    bit        live;
    bit [7:0]  v;
    verdict_t  vd;
    idx = cnt;
    live = idx < SAT_COUNT;
    if (live) begin
      case (idx)
        17'd0: ver = b;
        17'd1: typ = b;
        17'd2: len[15:8] = b;
        17'd3: len[7:0] = b;
        17'd12: ck[15:8] = b;
        17'd13: ck[7:0] = b;
        default: ;
      endcase
      if (idx >= 14 && idx <= 23 && b != 8'h00) auth = 1'b1;
      if (idx >= 28 && idx <= 31) adverts = {adverts[23:0], b};
      if ((idx == 30 || idx == 31) && b != 8'h00) pad = 1'b1;
      // checksum field itself counts as zero in the sum
      v = (idx == 12 || idx == 13) ? 8'h00 : b;
      if (!idx[0]) hi_hold = v;
      else sum = ones_acc(sum, {hi_hold, v});
      cnt = idx + 17'd1;
    end
    if (!fin) return;
    // odd length: pad the final byte with a zero low byte
    if (live && !idx[0]) sum = ones_acc(sum, {hi_hold, 8'h00});
    vd.code = verdict_code(dst, present);
    vd.ok = (vd.code == opv_pkg::ERR_OK);
    vd.kind = (typ == opv_pkg::TYPE_HELLO) ? opv_pkg::KIND_HELLO :
              ((typ == opv_pkg::TYPE_LSU) ? opv_pkg::KIND_LSU : opv_pkg::KIND_OTHER);
    verdicts_due.push_back(vd);
    cnt = '0; sum = '0; hi_hold = '0; ver = '0; typ = '0; len = '0; ck = '0;
    auth = 1'b0; pad = 1'b0; adverts = '0;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Result checker
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("unexpected verdict ok=%0d code=%0d kind=%0d at %0t",
                             packet_ok, error_code, packet_kind, $time));
      end else begin
        want = verdicts_due.pop_front();
        if (packet_ok !== want.ok || error_code !== want.code || packet_kind !== want.kind)
          flag_error($sformatf(
            "verdict mismatch at %0t: expected ok=%0d code=%0d kind=%0d, got ok=%0d code=%0d kind=%0d",
            $time, want.ok, want.code, want.kind, packet_ok, error_code, packet_kind));
      end
    end
  end

  // Receiver: random hold-offs, plus long holds on request
  initial begin : receiver
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 6) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_request == 0);
    end
  end

  task automatic send_item(input bit [7:0] b, input bit fin, input bit [31:0] dst,
                           input bit present);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    ip_dst <= dst;
    ip_header_present <= present;
    do @(posedge clk); while (in_stall);
    absorb_byte(b, fin, dst, present);
  endtask

  task automatic send_packet(input octets_t p, input bit [31:0] dst, input bit present);
    foreach (p[i]) send_item(p[i], i == p.size() - 1, dst, present);
  endtask

  function automatic void seal(inout octets_t p);
    bit [16:0] acc;
    bit [7:0]  h;
    bit [7:0]  l;
    bit [15:0] c;
    acc = '0;
    for (int i = 0; i < p.size(); i += 2) begin
      h = (i == 12) ? 8'h00 : p[i];
      l = (i + 1 < p.size() && i + 1 != 13) ? p[i + 1] : 8'h00;
      acc = ones_acc(acc, {h, l});
    end
    if (p.size() > 13) begin
      c = 16'hFFFF - acc[15:0];
      p[12] = c[15:8];
      p[13] = c[7:0];
    end
  endfunction

  // Well-formed packet of the given type and size, length field and checksum correct
  function automatic octets_t make_packet(bit [7:0] ptype, int total, bit [31:0] adv);
    octets_t p;
    bit [31:0] t;
    t = total;
    for (int i = 0; i < total; i++) begin
      if (i == 0) p.push_back(cur_version);
      else if (i == 1) p.push_back(ptype);
      else if (i == 2) p.push_back(t[15:8]);
      else if (i == 3) p.push_back(t[7:0]);
      else if (i >= 12 && i <= 23) p.push_back(8'h00);
      else if (ptype == opv_pkg::TYPE_HELLO && (i == 30 || i == 31)) p.push_back(8'h00);
      else if (ptype == opv_pkg::TYPE_LSU && i >= 28 && i <= 31)
        p.push_back(adv[8 * (31 - i) +: 8]);
      else p.push_back(8'($urandom));
    end
    seal(p);
    return p;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_version(input bit [7:0] v);
    wait_drained();
    cfg_write_data <= v;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_version = v;
  endtask

  task automatic test_good_packets();
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 32, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 44, 0), 32'hFFFF_FFFF, 1'b0);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 32, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 68, 3), 32'h0, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 33, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 45, 1), opv_pkg::HELLO_DST, 1'b0);
  endtask

  task automatic test_short_packets();
    send_packet(make_packet(8'hFF, 1, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 2, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 23, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 24, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 24, 0), opv_pkg::HELLO_DST, 1'b1);
  endtask

  task automatic test_header_faults();
    octets_t p;
    p = make_packet(opv_pkg::TYPE_HELLO, 32, 0);
    p[0] = cur_version ^ 8'h80; seal(p);
    send_packet(p, opv_pkg::HELLO_DST, 1'b1);
    p = make_packet(opv_pkg::TYPE_LSU, 32, 0);
    p[23] = 8'h01; seal(p);
    send_packet(p, opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(8'h00, 32, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(8'hFF, 40, 0), opv_pkg::HELLO_DST, 1'b1);
    p = make_packet(opv_pkg::TYPE_HELLO, 36, 0);
    p[13] = p[13] ^ 8'h01;
    send_packet(p, opv_pkg::HELLO_DST, 1'b1);
    p = make_packet(opv_pkg::TYPE_HELLO, 36, 0);
    p[3] = 8'd35; seal(p);
    send_packet(p, opv_pkg::HELLO_DST, 1'b1);
    p = make_packet(opv_pkg::TYPE_HELLO, 32, 0);
    p[31] = 8'h80; seal(p);
    send_packet(p, opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 32, 0), 32'hE000_0006, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 32, 0), 32'h1FFF_FFFA, 1'b0);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 44, 2), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 44, 32'hFFFF_FFFF), opv_pkg::HELLO_DST, 1'b1);
  endtask

  task automatic test_version_register();
    octets_t p;
    bit [7:0] vals[4];
    vals = '{8'h00, 8'hFF, 8'($urandom), opv_pkg::VERSION_RESET};
    foreach (vals[i]) begin
      set_version(vals[i]);
      send_packet(make_packet(opv_pkg::TYPE_HELLO, 32, 0), opv_pkg::HELLO_DST, 1'b1);
      p = make_packet(opv_pkg::TYPE_LSU, 44, 1);
      p[0] = ~cur_version; seal(p);
      send_packet(p, opv_pkg::HELLO_DST, 1'b1);
    end
  endtask

  // Receiver holds off while one-byte packets keep coming, so the input stalls
  task automatic test_backpressure();
    wait_drained();
    tx_idle = 1'b0;
    hold_request = 60;
    repeat (10) send_packet(make_packet(opv_pkg::TYPE_LSU, 1, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_HELLO, 32, 0), opv_pkg::HELLO_DST, 1'b1);
    send_packet(make_packet(opv_pkg::TYPE_LSU, 56, 2), opv_pkg::HELLO_DST, 1'b1);
    tx_idle = 1'b1;
    wait_drained();
  endtask

  task automatic random_packet(output octets_t p, output bit [31:0] dst, output bit present);
    int unsigned sel;
    int unsigned fault;
    int total;
    bit [31:0] adv;
    bit [31:0] adv_hdr;
    bit [7:0] ptype;
    p = {};
    dst = opv_pkg::HELLO_DST;
    present = $urandom_range(0, 3) != 0;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      // plain noise
      total = $urandom_range(1, 48);
      repeat (total) p.push_back(8'($urandom));
      dst = $urandom;
      present = 1'($urandom_range(0, 1));
      return;
    end
    ptype = (sel < 4) ? opv_pkg::TYPE_HELLO :
            ((sel < 8) ? opv_pkg::TYPE_LSU : 8'($urandom));
    adv = $urandom_range(0, 3);
    if (ptype == opv_pkg::TYPE_HELLO)
      total = 32 + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0);
    else if (ptype == opv_pkg::TYPE_LSU)
      total = 32 + 12 * adv + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0);
    else
      total = $urandom_range(24, 48);
    fault = $urandom_range(0, 15);
    adv_hdr = adv;
    if (fault == 7) total = $urandom_range(2, 31);
    if (fault == 8 && ptype == opv_pkg::TYPE_LSU)
      adv_hdr = ($urandom_range(0, 3) == 0) ? $urandom : adv + $urandom_range(1, 3);
    p = make_packet(ptype, total, adv_hdr);
    case (fault)
      8: if (ptype == opv_pkg::TYPE_HELLO) begin
        p[$urandom_range(30, 31)] = 8'($urandom_range(1, 255)); seal(p);
      end
      9: begin p[0] = 8'($urandom); seal(p); end
      10: begin p[$urandom_range(14, 23)] = 8'($urandom_range(1, 255)); seal(p); end
      11: begin p[2] = 8'($urandom); p[3] = 8'($urandom); seal(p); end
      12: begin dst = $urandom; present = 1'b1; end
      13: p[$urandom_range(12, 13)] ^= 8'($urandom_range(1, 255));
      14: p[$urandom_range(0, p.size() - 1)] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
  endtask

  task automatic test_random_traffic();
    octets_t p;
    bit [31:0] dst;
    bit present;
    int unsigned items;
    int unsigned packets;
    bit [7:0] v;
    items = 0;
    packets = 0;
    while (items < 600 || packets < 16) begin
      if ($urandom_range(0, 7) == 0) tx_idle = ~tx_idle;
      if ($urandom_range(0, 7) == 0) rx_idle = ~rx_idle;
      if (packets % 12 == 11) begin
        case ($urandom_range(0, 3))
          0: v = 8'h00;
          1: v = 8'hFF;
          2: v = opv_pkg::VERSION_RESET;
          default: v = 8'($urandom);
        endcase
        set_version(v);
      end
      random_packet(p, dst, present);
      send_packet(p, dst, present);
      items += p.size();
      packets++;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_good_packets();
    test_short_packets();
    test_header_faults();
    test_version_register();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/opv_pkg.sv
sv/opv_front.sv
sv/opv_queue.sv
sv/opv_back.sv
sv/ospf_packet_validator.sv
test/tb.sv
